FILE: sv/awd_pkg.sv
`timescale 1ns / 1ps
// types and constants shared by the address window decoder files
package awd_pkg;

    localparam int ADDR_W = 16;
    localparam int SLOT_W = 4;
    localparam int DATA_W = 8;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_READ     = 2'd2,
        OP_WRITE    = 2'd3
    } awd_op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISS    = 2'd3
    } awd_status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_SCAN = 1'b1
    } awd_fsm_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] window_size;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] write_data;
    } awd_cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] hit_slot;
        logic [ADDR_W-1:0] offset;
        logic              is_write;
        logic [DATA_W-1:0] out_data;
    } awd_rsp_t;

    // query token that walks down the row of cells
    typedef struct packed {
        logic              go;
        awd_op_t           op;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] probe_mid;
        logic [ADDR_W-1:0] probe_end;
        logic [ADDR_W-1:0] window_size;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] write_data;
        logic              found;
        logic [SLOT_W-1:0] found_idx;
        logic [ADDR_W-1:0] found_offset;
        logic              free_found;
        logic [SLOT_W-1:0] free_idx;
    } awd_tok_t;

    // table update broadcast to all cells
    typedef struct packed {
        logic              set;
        logic              clr;
        logic [SLOT_W-1:0] idx;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] length;
    } awd_wr_t;

endpackage

FILE: sv/awd_cell.sv
`timescale 1ns / 1ps
// one table entry with its window compare stage
module awd_cell
    import awd_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  awd_wr_t  wr,
    input  awd_tok_t tok_in,
    output awd_tok_t tok_out
);

    logic              valid_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] length_reg;
    logic              go_reg;
    awd_tok_t          tok_reg;
    awd_tok_t          tok_next;
    logic              hit_a;
    logic              hit_m;
    logic              hit_e;
    logic [ADDR_W:0]   limit;
    logic              my_slot;

    assign my_slot = (wr.idx == SLOT_W'(IDX));
    assign limit   = {1'b0, base_reg} + {1'b0, length_reg};

    // window holds probe when base <= probe < base + length, sum not wrapped
    assign hit_a = valid_reg && (base_reg <= tok_in.address)
                   && (limit > {1'b0, tok_in.address});
    assign hit_m = valid_reg && (base_reg <= tok_in.probe_mid)
                   && (limit > {1'b0, tok_in.probe_mid});
    assign hit_e = valid_reg && (base_reg <= tok_in.probe_end)
                   && (limit > {1'b0, tok_in.probe_end});

    always_comb
    begin
        tok_next = tok_in;
        case (tok_in.op)
            OP_REGISTER:
            begin
                if (hit_a || hit_m || hit_e)
                begin
                    tok_next.found = 1'b1;
                end
                if (!tok_in.free_found && !valid_reg)
                begin
                    tok_next.free_found = 1'b1;
                    tok_next.free_idx   = SLOT_W'(IDX);
                end
            end
            OP_READ, OP_WRITE:
            begin
                if (!tok_in.found && hit_a)
                begin
                    tok_next.found        = 1'b1;
                    tok_next.found_idx    = SLOT_W'(IDX);
                    tok_next.found_offset = tok_in.address - base_reg;
                end
            end
            default:
            begin
                tok_next = tok_in;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            go_reg    <= 1'b0;
        end
        else
        begin
            go_reg <= tok_in.go;
            if (wr.set && my_slot)
            begin
                valid_reg <= 1'b1;
            end
            else if (wr.clr && my_slot)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (wr.set && my_slot)
        begin
            base_reg   <= wr.base;
            length_reg <= wr.length;
        end
    end

    always_comb
    begin
        tok_out    = tok_reg;
        tok_out.go = go_reg;
    end

endmodule

FILE: sv/address_window_decoder.sv
`timescale 1ns / 1ps
// address window decoder top level: command control, cell row, result register
//
// channel   | signals              | handshake
// ----------+----------------------+----------------------------------------
// command   | start, busy, cmd     | taken at a clock edge with start & !busy
// response  | done, rsp            | done high one cycle, receiver cannot stall
//
// one transaction at a time: the command token enters cell 0 at the accepting edge
// and moves one cell per cycle; at the edge where it leaves the last cell the table
// update and the response register load, and busy stays high until that edge
// done rises at the edge where busy falls and stays high for one cycle; a new command
// may be taken in that cycle
// reset clears the valid marks and the control state, no clearing pass is needed
// the response side has no backpressure, every response is delivered on done
module address_window_decoder
    import awd_pkg::*;
#(
    parameter int SLOTS = 10
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  awd_cmd_t cmd,
    output logic     done,
    output awd_rsp_t rsp
);

    awd_fsm_t  state_reg;
    awd_fsm_t  state_next;
    awd_tok_t  tok [SLOTS+1];
    awd_tok_t  tail;
    awd_wr_t   wr;
    awd_rsp_t  rsp_reg;
    awd_rsp_t  rsp_next;
    logic      done_reg;
    logic      accept;
    logic      slot_in_range;
    logic [SLOTS-1:0] go_vec;

    assign busy   = (state_reg == FSM_SCAN);
    assign accept = start && !busy;

    // head token straight from the command port, probes formed here once
    always_comb
    begin
        tok[0]              = '0;
        tok[0].go           = accept;
        tok[0].op           = awd_op_t'(cmd.op);
        tok[0].address      = cmd.address;
        tok[0].probe_mid    = cmd.address + {1'b0, cmd.window_size[ADDR_W-1:1]};
        tok[0].probe_end    = cmd.address + cmd.window_size;
        tok[0].window_size  = cmd.window_size;
        tok[0].slot         = cmd.slot;
        tok[0].write_data   = cmd.write_data;
    end

    // row of cells, one table entry each, token registered between neighbors
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        awd_cell #(
            .IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (wr),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
        assign go_vec[i] = tok[i+1].go;
    end

    assign tail = tok[SLOTS];
    assign slot_in_range = ({1'b0, tail.slot} < (SLOT_W+1)'(SLOTS));

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    state_next = FSM_SCAN;
                end
            end
            FSM_SCAN:
            begin
                // token leaving the last cell finishes the transaction
                if (tail.go)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // response and table update from the token at the end of the row
    always_comb
    begin
        rsp_next  = '0;
        wr        = '0;
        wr.idx    = tail.free_idx;
        wr.base   = tail.address;
        wr.length = tail.window_size;
        case (tail.op)
            OP_REGISTER:
            begin
                if (tail.found)
                begin
                    rsp_next.status = ST_OVERLAP;
                end
                else if (!tail.free_found)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    rsp_next.status   = ST_OK;
                    rsp_next.hit_slot = tail.free_idx;
                    wr.set            = tail.go;
                end
            end
            OP_REMOVE:
            begin
                rsp_next.status = ST_OK;
                wr.idx          = tail.slot;
                wr.clr          = tail.go && slot_in_range;
            end
            OP_READ, OP_WRITE:
            begin
                rsp_next.is_write = (tail.op == OP_WRITE);
                if (tail.found)
                begin
                    rsp_next.status   = ST_OK;
                    rsp_next.hit_slot = tail.found_idx;
                    rsp_next.offset   = tail.found_offset;
                    if (tail.op == OP_WRITE)
                    begin
                        rsp_next.out_data = tail.write_data;
                    end
                end
                else
                begin
                    rsp_next.status = ST_MISS;
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tail.go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.go)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // a response only comes once the scan has ended
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response while scan still running");

    // an accepted command holds off the next one
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accept");

    // at most one token in the row of cells
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(go_vec))
        else $error("more than one token in the cell row");

    // a token only moves while a transaction is open
    a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (go_vec != '0) |-> busy)
        else $error("token in the row while idle");

    // misses report no slot and no offset
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_MISS) |-> (rsp.hit_slot == '0 && rsp.offset == '0))
        else $error("miss response carries slot or offset");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the address window decoder
module testbench;
    import awd_pkg::*;

    localparam int SLOTS = 10;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    awd_cmd_t cmd;
    logic     done;
    awd_rsp_t rsp;

    // shadow copy of the window table, updated when a transaction is accepted
    logic [ADDR_W-1:0] win_base [SLOTS];
    logic [ADDR_W-1:0] win_len  [SLOTS];
    bit                win_valid[SLOTS];

    awd_rsp_t pending_rsp[$];
    int       mismatch_count = 0;

    address_window_decoder #(.SLOTS(SLOTS)) u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // lowest valid window holding the address; the window end is taken at 17 bits
    function automatic int lookup_window(input logic [ADDR_W:0] addr);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (win_valid[i] && {1'b0, win_base[i]} <= addr
                && ({1'b0, win_base[i]} + {1'b0, win_len[i]}) > addr)
                return i;
        end
        return -1;
    endfunction

    // expected response of one transaction, applying its effect on the window table
    function automatic awd_rsp_t predict_decode(input awd_cmd_t c);
        awd_rsp_t          r;
        int                idx;
        logic [ADDR_W-1:0] mid;
        logic [ADDR_W-1:0] tail;
        r = '0;
        case (awd_op_t'(c.op))
            OP_REGISTER:
            begin
                mid  = c.address + (c.window_size >> 1);
                tail = c.address + c.window_size;
                if (lookup_window({1'b0, c.address}) >= 0 || lookup_window({1'b0, mid}) >= 0
                    || lookup_window({1'b0, tail}) >= 0)
                    r.status = ST_OVERLAP;
                else
                begin
                    idx = -1;
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!win_valid[i])
                            idx = i;
                    if (idx < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        win_base[idx]  = c.address;
                        win_len[idx]   = c.window_size;
                        win_valid[idx] = 1'b1;
                        r.hit_slot     = idx[SLOT_W-1:0];
                    end
                end
            end
            OP_REMOVE:
            begin
                if (c.slot < SLOTS)
                begin
                    win_valid[c.slot] = 1'b0;
                    win_base[c.slot]  = '0;
                    win_len[c.slot]   = '0;
                end
            end
            default:
            begin
                r.is_write = (awd_op_t'(c.op) == OP_WRITE);
                idx = lookup_window({1'b0, c.address});
                if (idx < 0)
                    r.status = ST_MISS;
                else
                begin
                    r.hit_slot = idx[SLOT_W-1:0];
                    r.offset   = c.address - win_base[idx];
                    if (r.is_write)
                        r.out_data = c.write_data;
                end
            end
        endcase
        return r;
    endfunction

    // fields that the operation ignores carry random junk
    function automatic awd_cmd_t mk_cmd(input awd_op_t op, input logic [ADDR_W-1:0] address,
                                        input logic [ADDR_W-1:0] size,
                                        input logic [SLOT_W-1:0] slot,
                                        input logic [DATA_W-1:0] data);
        awd_cmd_t c;
        c.op          = op;
        c.address     = (op == OP_REMOVE) ? ADDR_W'($urandom) : address;
        c.window_size = (op == OP_REGISTER) ? size : ADDR_W'($urandom);
        c.slot        = (op == OP_REMOVE) ? slot : SLOT_W'($urandom);
        c.write_data  = (op == OP_WRITE) ? data : DATA_W'($urandom);
        return c;
    endfunction

    // start stays high until the block takes the transaction
    task automatic issue_cmd(input awd_cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        pending_rsp.push_back(predict_decode(c));
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_for_responses();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // response checker: done marks one response, taken at the edge that ends it
    always @(posedge clk)
    begin
        awd_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: response with none expected, expected nothing, actual %p",
                         $time, rsp);
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("status",   want.status,   rsp.status);
                check_field("hit_slot", want.hit_slot, rsp.hit_slot);
                check_field("offset",   want.offset,   rsp.offset);
                check_field("is_write", want.is_write, rsp.is_write);
                check_field("out_data", want.out_data, rsp.out_data);
            end
        end
    end

    task automatic test_empty_table();
        issue_cmd(mk_cmd(OP_READ,  16'h0000, 0, 0, 0));
        issue_cmd(mk_cmd(OP_WRITE, 16'hFFFF, 0, 0, 8'hA5));
    endtask

    task automatic test_register_rules();
        issue_cmd(mk_cmd(OP_REGISTER, 16'h1000, 16'h0100, 0, 0));
        // middle probe lands in the first window
        issue_cmd(mk_cmd(OP_REGISTER, 16'h1080, 16'h0010, 0, 0));
        // no probe lands in the first window although the new one covers it
        issue_cmd(mk_cmd(OP_REGISTER, 16'h0F00, 16'h0400, 0, 0));
        // window reaching past the top of the address space
        issue_cmd(mk_cmd(OP_REGISTER, 16'hFFF0, 16'hFFFF, 0, 0));
        idle_cycles(3);
        // zero length window holds nothing
        issue_cmd(mk_cmd(OP_REGISTER, 16'h2000, 16'h0000, 0, 0));
        // end probe hits the window at the top of the address space
        issue_cmd(mk_cmd(OP_REGISTER, 16'h0000, 16'hFFFF, 0, 0));
    endtask

    task automatic test_access_hits();
        issue_cmd(mk_cmd(OP_READ,  16'h1000, 0, 0, 0));
        // two windows hold this address, the lower slot wins
        issue_cmd(mk_cmd(OP_READ,  16'h1010, 0, 0, 0));
        issue_cmd(mk_cmd(OP_WRITE, 16'h12FF, 0, 0, 8'h00));
        issue_cmd(mk_cmd(OP_READ,  16'h1300, 0, 0, 0));
        issue_cmd(mk_cmd(OP_READ,  16'h2000, 0, 0, 0));
        issue_cmd(mk_cmd(OP_WRITE, 16'hFFFF, 0, 0, 8'hFF));
    endtask

    task automatic test_table_full();
        for (int i = 0; i < SLOTS - 4; i++)
            issue_cmd(mk_cmd(OP_REGISTER, 16'h4000 + 16'(i) * 16'h1000, 16'h0800, 0, 0));
        issue_cmd(mk_cmd(OP_REGISTER, 16'hB000, 16'h0010, 0, 0));
    endtask

    task automatic test_remove();
        issue_cmd(mk_cmd(OP_REMOVE, 0, 0, 4'hF, 0));
        issue_cmd(mk_cmd(OP_REMOVE, 0, 0, 4'(SLOTS), 0));
        issue_cmd(mk_cmd(OP_REMOVE, 0, 0, 4'd3, 0));
        // removing a free slot changes nothing
        issue_cmd(mk_cmd(OP_REMOVE, 0, 0, 4'd3, 0));
        // lowest free slot is claimed again
        issue_cmd(mk_cmd(OP_REGISTER, 16'hB000, 16'h0010, 0, 0));
    endtask

    // mixed traffic; accesses mostly aimed into live windows so that hits dominate
    task automatic test_random_traffic(input int count, input bit gaps);
        int                pick;
        int                live[$];
        int                s;
        logic [ADDR_W:0]   addr;
        logic [ADDR_W-1:0] size;
        awd_cmd_t          c;
        for (int n = 0; n < count; n++)
        begin
            live = {};
            for (int i = 0; i < SLOTS; i++)
                if (win_valid[i])
                    live.push_back(i);
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                case ($urandom_range(0, 7))
                    0:       size = '0;
                    1:       size = '1;
                    2:       size = ADDR_W'($urandom);
                    default: size = ADDR_W'($urandom_range(1, 16'h0400));
                endcase
                addr = {1'b0, ADDR_W'($urandom)};
                if (live.size() != 0 && $urandom_range(0, 3) == 0)
                begin
                    s    = live[$urandom_range(0, live.size() - 1)];
                    addr = win_base[s] + ADDR_W'($urandom_range(0, 16'h0200)) - 16'h0100;
                end
                c = mk_cmd(OP_REGISTER, addr[ADDR_W-1:0], size, 0, 0);
            end
            else if (pick < 50)
            begin
                s = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(0, SLOTS - 1);
                c = mk_cmd(OP_REMOVE, 0, 0, SLOT_W'(s), 0);
            end
            else
            begin
                addr = {1'b0, ADDR_W'($urandom)};
                if (live.size() != 0 && $urandom_range(0, 4) != 0)
                begin
                    s    = live[$urandom_range(0, live.size() - 1)];
                    addr = {1'b0, win_base[s]}
                           + (ADDR_W+1)'($urandom_range(0, win_len[s]));
                end
                c = mk_cmd($urandom_range(0, 1) ? OP_WRITE : OP_READ, addr[ADDR_W-1:0], 0, 0,
                           DATA_W'($urandom));
            end
            issue_cmd(c);
            if (gaps && $urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 14));
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd   <= '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            win_valid[i] = 1'b0;
            win_base[i]  = '0;
            win_len[i]   = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_register_rules();
        test_access_hits();
        test_table_full();
        test_remove();
        // sender holds off until the block has answered everything
        wait_for_responses();
        test_random_traffic(180, 1'b1);
        wait_for_responses();
        test_random_traffic(130, 1'b1);
        // back to back tail with no idling
        test_random_traffic(70, 1'b0);

        wait_for_responses();
        repeat (SLOTS + 4) @(posedge clk);
        if (mismatch_count == 0 && pending_rsp.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // run limit
    initial
    begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
